/* rtl/mmsg8_pkg.sv */
// Shared types, constants and the sample decoder for the min/max grey stretch unit.
`default_nettype none
package mmsg8_pkg;

    localparam int SAMPLE_WIDTH = 32;

    // Signed working width of a decoded sample, min and max.
    localparam int VAL_W  = 33;
    // Differences of two values.
    localparam int DIFF_W = VAL_W + 1;
    // Dividend diff*255 and the shifted divisor of the restoring divider.
    localparam int NUM_W  = VAL_W + 8;
    localparam int QUOT_W = 8;
    localparam int STEP_W = $clog2(QUOT_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FMT_W = 3;
    localparam logic [FMT_W-1:0] FMT_INT8   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_UINT8  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_INT16  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_UINT16 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_INT32  = 3'd4;
    localparam logic [FMT_W-1:0] FMT_RESET  = FMT_UINT8;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_MAP     = 1'b1;

    localparam logic [QUOT_W-1:0] GREY_MIN = 8'd0;
    localparam logic [QUOT_W-1:0] GREY_MAX = 8'd255;

    // Format widths, clipped to the sample width.
    localparam logic [5:0] W8  = 6'((SAMPLE_WIDTH < 8)  ? SAMPLE_WIDTH : 8);
    localparam logic [5:0] W16 = 6'((SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16);
    localparam logic [5:0] W32 = 6'((SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32);

    typedef struct packed {
        logic                    is_map;
        logic                    first;
        logic signed [VAL_W-1:0] value;
    } item_t;

    function automatic logic signed [VAL_W-1:0] decode_sample(
        input logic [31:0]      bits,
        input logic [FMT_W-1:0] fmt
    );
        logic [5:0]       w;
        logic             sgn;
        logic             neg;
        logic [32:0]      bits_ext;
        logic [VAL_W-1:0] v;
        case (fmt)
            FMT_INT8:
            begin
                w   = W8;
                sgn = 1'b1;
            end
            FMT_UINT8:
            begin
                w   = W8;
                sgn = 1'b0;
            end
            FMT_INT16:
            begin
                w   = W16;
                sgn = 1'b1;
            end
            FMT_UINT16:
            begin
                w   = W16;
                sgn = 1'b0;
            end
            FMT_INT32:
            begin
                w   = W32;
                sgn = 1'b1;
            end
            default:
            begin
                w   = W32;
                sgn = 1'b0;
            end
        endcase
        bits_ext = {1'b0, bits};
        neg = sgn & bits_ext[w - 6'd1];
        for (int i = 0; i < VAL_W; i++)
        begin
            if (i < w)
            begin
                v[i] = bits_ext[i];
            end
            else
            begin
                v[i] = neg;
            end
        end
        return $signed(v);
    endfunction

endpackage
`default_nettype wire

/* rtl/mmsg8_front.sv */
// Front end: format register, sample decode and push of classified beats into the queue.
`default_nettype none
module mmsg8_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [mmsg8_pkg::FMT_W-1:0]  cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         op,
    input  wire logic [31:0]                  sample_bits,
    input  wire logic                         first,
    input  wire logic                         q_full,
    output logic                              push,
    output mmsg8_pkg::item_t                  push_item
);

    logic [mmsg8_pkg::FMT_W-1:0] fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= mmsg8_pkg::FMT_RESET;
        end
        else if (cfg_wr_en)
        begin
            fmt_reg <= cfg_wr_data;
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.is_map = (op == mmsg8_pkg::OP_MAP);
        push_item.first  = first;
        push_item.value  = mmsg8_pkg::decode_sample(sample_bits, fmt_reg);
    end

endmodule
`default_nettype wire

/* rtl/mmsg8_queue.sv */
// Short in-order queue of classified beats between front end and back end.
`default_nettype none
module mmsg8_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mmsg8_pkg::item_t  push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output mmsg8_pkg::item_t       head_item
);

    mmsg8_pkg::item_t                    entry_reg [mmsg8_pkg::QUEUE_DEPTH];
    logic [mmsg8_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [mmsg8_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [mmsg8_pkg::QCNT_W-1:0]        count_reg, count_next;

    localparam logic [mmsg8_pkg::QPTR_W-1:0] LAST =
        mmsg8_pkg::QPTR_W'(mmsg8_pkg::QUEUE_DEPTH - 1);
    localparam logic [mmsg8_pkg::QCNT_W-1:0] CNT_FULL =
        mmsg8_pkg::QCNT_W'(mmsg8_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

/* rtl/mmsg8_back.sv */
// Back end: running min/max update, range setup, restoring divider and output register.
`default_nettype none
module mmsg8_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  wire mmsg8_pkg::item_t              head_item,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [mmsg8_pkg::QUOT_W-1:0]       grey
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } back_state_t;

    back_state_t                               state_reg, state_next;
    logic signed [mmsg8_pkg::VAL_W-1:0]        min_reg, min_next;
    logic signed [mmsg8_pkg::VAL_W-1:0]        max_reg, max_next;
    logic signed [mmsg8_pkg::VAL_W-1:0]        sample_reg, sample_next;
    logic [mmsg8_pkg::NUM_W-1:0]               num_reg, num_next;
    logic [mmsg8_pkg::NUM_W-1:0]               den_reg, den_next;
    logic [mmsg8_pkg::QUOT_W-1:0]              quot_reg, quot_next;
    logic [mmsg8_pkg::STEP_W-1:0]              step_reg, step_next;
    logic                                      out_valid_reg, out_valid_next;
    logic [mmsg8_pkg::QUOT_W-1:0]              grey_reg, grey_next;

    logic signed [mmsg8_pkg::DIFF_W-1:0]       diff;
    logic signed [mmsg8_pkg::DIFF_W-1:0]       span;
    logic                                      take;

    assign diff = mmsg8_pkg::DIFF_W'(sample_reg) - mmsg8_pkg::DIFF_W'(min_reg);
    assign span = mmsg8_pkg::DIFF_W'(max_reg) - mmsg8_pkg::DIFF_W'(min_reg);
    assign take = (num_reg >= den_reg);

    assign out_valid = out_valid_reg;
    assign grey      = grey_reg;

    always_comb
    begin
        state_next     = state_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sample_next    = sample_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        grey_next      = grey_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_item.is_map)
                    begin
                        sample_next = head_item.value;
                        state_next  = S_PREP;
                    end
                    else if (head_item.first)
                    begin
                        min_next = head_item.value;
                        max_next = head_item.value;
                    end
                    else if (head_item.value > max_reg)
                    begin
                        max_next = head_item.value;
                    end
                    else if (head_item.value < min_reg)
                    begin
                        min_next = head_item.value;
                    end
                end
            end
            S_PREP:
            begin
                // Saturate empty range, below-min and above-max cases without dividing.
                if (span[mmsg8_pkg::DIFF_W-1] || span == '0 ||
                    diff[mmsg8_pkg::DIFF_W-1] || diff == '0)
                begin
                    quot_next  = mmsg8_pkg::GREY_MIN;
                    state_next = S_DONE;
                end
                else if (diff >= span)
                begin
                    quot_next  = mmsg8_pkg::GREY_MAX;
                    state_next = S_DONE;
                end
                else
                begin
                    // diff*255 as (diff << 8) - diff; divisor starts at range << 7.
                    num_next   = {diff[mmsg8_pkg::VAL_W-1:0], 8'd0}
                               - {8'd0, diff[mmsg8_pkg::VAL_W-1:0]};
                    den_next   = {1'b0, span[mmsg8_pkg::VAL_W-1:0], 7'd0};
                    quot_next  = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (take)
                begin
                    num_next = num_reg - den_reg;
                end
                quot_next = {quot_reg[mmsg8_pkg::QUOT_W-2:0], take};
                den_next  = den_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == mmsg8_pkg::STEP_W'(mmsg8_pkg::QUOT_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the output register once the previous beat has left.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    grey_next      = quot_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= '0;
            max_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        quot_reg   <= quot_next;
        grey_reg   <= grey_next;
    end

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, num_reg} < {den_reg, 1'b0}))
        else $error("divider remainder out of bound");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output loaded outside done state");

    a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("queue popped while busy");

endmodule
`default_nettype wire

/* rtl/min_max_stretch_to_grey8_unit.sv */
// Top level of the min/max contrast stretch to 8-bit grey.
`default_nettype none
// Measure beats fold a decoded sample into the running minimum and maximum (first restarts
// both); map beats return floor((sample - min) * 255 / (max - min)), 0 for an empty range or
// a sample at or below min, 255 at or above max. A two-beat queue sits between the decode
// front end and the back end, so input beats keep flowing while the back end works, as long
// as the queue is not full. In the back end a measure beat is folded in as it is taken from
// the queue; a map beat is taken from the queue, then range and difference are formed, then
// eight steps of the restoring divider produce one quotient bit each, and then the output
// register is loaded once the previous result has left. Saturated map beats skip the
// divider. sample_format must be written while the unit is idle; it applies to beats accepted after the write.
module min_max_stretch_to_grey8_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mmsg8_pkg::FMT_W-1:0]   cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [31:0]                   sample_bits,
    input  wire logic                          first,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         grey
);

    logic             q_full;
    logic             push;
    mmsg8_pkg::item_t push_item;
    logic             pop;
    logic             head_valid;
    mmsg8_pkg::item_t head_item;

    mmsg8_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .sample_bits (sample_bits),
        .first       (first),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    mmsg8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mmsg8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .grey       (grey)
    );

endmodule
`default_nettype wire
